/* src/sirt_pkg.sv */
package sirt_pkg;

    localparam int VALUE_W             = 32;
    localparam int CHAR_W              = 8;
    localparam int CFG_SIZE_W          = 5;
    localparam int SYM_WORD_W          = 64;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 64;
    localparam int NUM_SLOTS           = 16;
    localparam int SLOT_W              = 4;
    localparam int DEFAULT_MAX_SYMBOLS = 16;
    localparam int DIGITS_MAX          = 32;
    localparam int DIGIT_IDX_W         = 5;
    localparam int DIV_STEPS           = 8;
    localparam int DIV_ITERS           = VALUE_W / DIV_STEPS;
    localparam int DIV_CNT_W           = $clog2(DIV_ITERS);

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LOW   = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_HIGH  = 8'd127;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHABET_SIZE = 2'd0,
        REG_SYMBOLS_LOW   = 2'd1,
        REG_SYMBOLS_HIGH  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [VALUE_W-1:0]    dividend;
        logic [CFG_SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_W-1:0]    quotient;
        logic [CFG_SIZE_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic char_bad(input logic [CHAR_W-1:0] c);
        return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_SPACE) ||
               (c < CHAR_LOW) || (c >= CHAR_HIGH);
    endfunction

endpackage

/* src/signed_integer_to_radix_text.sv */
// Each digit costs one pass of the divider, which serves every digit in turn.
// A new value is taken only in idle, once the previous one is finished or dropped.
// A bad alphabet size drops the value at once; a bad symbol ends it during the symbol check.
// rst_n is asynchronous and active low; it clears the configuration and the sequencer to idle.
module signed_integer_to_radix_text
    import sirt_pkg::*;
#(
    parameter int MAX_SYMBOLS = DEFAULT_MAX_SYMBOLS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      strobe,
    output logic [CHAR_W-1:0]         char_code,
    output logic                      last_char,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    localparam int SYM_W = $clog2(MAX_SYMBOLS);

    logic [CFG_SIZE_W-1:0] size_reg;
    logic [SYM_WORD_W-1:0] symbols_low_reg;
    logic [SYM_WORD_W-1:0] symbols_high_reg;
    logic [2*SYM_WORD_W-1:0] all_sym;

    state_t                 state_reg, state_next;
    logic [SYM_W-1:0]       chk_reg, chk_next;
    logic [VALUE_W-1:0]     mag_reg, mag_next;
    logic                   neg_reg, neg_next;
    logic [DIGIT_IDX_W-1:0] nd_reg, nd_next;
    logic [DIGIT_IDX_W-1:0] ptr_reg, ptr_next;
    logic                   strobe_reg, strobe_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;
    logic [SYM_W-1:0]       stack_reg [DIGITS_MAX];
    logic                   push;

    logic                   size_ok;
    logic [CHAR_W-1:0]      chk_char;
    logic                   chk_bad;
    logic                   chk_last;
    logic [CFG_SIZE_W-1:0]  chk_ext;

    div_req_t div_req;
    div_rsp_t div_rsp;

    sirt_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg         <= '0;
            symbols_low_reg  <= '0;
            symbols_high_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ALPHABET_SIZE: size_reg         <= cfg_data[CFG_SIZE_W-1:0];
                REG_SYMBOLS_LOW:   symbols_low_reg  <= cfg_data;
                REG_SYMBOLS_HIGH:  symbols_high_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign all_sym = {symbols_high_reg, symbols_low_reg};

    function automatic logic [CHAR_W-1:0] sym_at(input logic [2*SYM_WORD_W-1:0] s,
                                                 input logic [SLOT_W-1:0] idx);
        return s[idx*CHAR_W +: CHAR_W];
    endfunction

    assign size_ok  = (size_reg >= CFG_SIZE_W'(2)) &&
                      (size_reg <= CFG_SIZE_W'(MAX_SYMBOLS));
    assign chk_ext  = CFG_SIZE_W'(chk_reg);
    assign chk_char = sym_at(all_sym, SLOT_W'(chk_reg));
    assign chk_last = (chk_ext == size_reg - 1'b1);

    // The symbol under check is compared against every later symbol in use.
    always_comb
    begin
        chk_bad = char_bad(chk_char);
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            if ((CFG_SIZE_W'(j) > chk_ext) && (CFG_SIZE_W'(j) < size_reg) &&
                (sym_at(all_sym, SLOT_W'(j)) == chk_char))
            begin
                chk_bad = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        chk_next         = chk_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        nd_next          = nd_reg;
        ptr_next         = ptr_reg;
        strobe_next      = 1'b0;
        char_next        = char_reg;
        last_next        = 1'b0;
        push             = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mag_reg;
        div_req.divisor  = size_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && size_ok)
                begin
                    neg_next   = value[VALUE_W-1];
                    mag_next   = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value))
                                                  : VALUE_W'(value);
                    chk_next   = '0;
                    nd_next    = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (chk_bad)
                begin
                    state_next = ST_IDLE;
                end
                else if (chk_last)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    chk_next = chk_reg + 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    push    = 1'b1;
                    nd_next = nd_reg + 1'b1;
                    if ((div_rsp.quotient != '0) && (nd_reg != '1))
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                    end
                    else
                    begin
                        ptr_next   = nd_reg;
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                    end
                end
            end
            ST_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_MINUS;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = sym_at(all_sym, SLOT_W'(stack_reg[ptr_reg]));
                last_next   = (ptr_reg == '0);
                if (ptr_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_reg  <= chk_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        nd_reg   <= nd_next;
        ptr_reg  <= ptr_next;
        char_reg <= char_next;
        if (push)
        begin
            stack_reg[nd_reg] <= div_rsp.remainder[SYM_W-1:0];
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

endmodule

/* src/sirt_divider.sv */
module sirt_divider
    import sirt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [VALUE_W-1:0]    quo_reg, quo_next;
    logic [CFG_SIZE_W-1:0] rem_reg, rem_next;
    logic [CFG_SIZE_W-1:0] dvs_reg, dvs_next;

    logic [VALUE_W-1:0]    q_step;
    logic [CFG_SIZE_W-1:0] r_step;
    logic [CFG_SIZE_W-1:0] trial;

    // Restoring division, several quotient bits per cycle. The remainder
    // stays below the divisor, so its top bit is always free for the shift.
    always_comb
    begin
        q_step = quo_reg;
        r_step = rem_reg;
        trial  = '0;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            trial = {r_step[CFG_SIZE_W-2:0], q_step[VALUE_W-1]};
            if (trial >= dvs_reg)
            begin
                r_step = trial - dvs_reg;
                q_step = {q_step[VALUE_W-2:0], 1'b1};
            end
            else
            begin
                r_step = trial;
                q_step = {q_step[VALUE_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = q_step;
            rem_next = r_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_ITERS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* src/sirt_checker.sv */
module sirt_checker
    import sirt_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      strobe,
    input logic [CHAR_W-1:0]         char_code,
    input logic                      last_char
);

    // A character beat only follows a cycle in which the block was busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("character beat without a busy cycle before it");

    // The final character of a number is never directly followed by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_char |=> !strobe)
        else $error("character beat right after the final character");

    // A newly taken value cannot produce a character in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> !strobe)
        else $error("character beat right after a value was taken");

    // The sign is never the final character.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (char_code == CHAR_MINUS) |-> !last_char)
        else $error("sign flagged as the final character");

    // Every character is printable and neither a plus nor a space.
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (char_code > CHAR_SPACE) && (char_code < CHAR_HIGH) &&
                   (char_code != CHAR_PLUS))
        else $error("character outside the allowed set");

endmodule

bind signed_integer_to_radix_text sirt_checker u_sirt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
);
